// ===== rtl/core/dual_scale_channel_histogram_macros.svh =====
// Assertion helpers for the checker file.
`ifndef DUAL_SCALE_CHANNEL_HISTOGRAM_MACROS_SVH
`define DUAL_SCALE_CHANNEL_HISTOGRAM_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DSCH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DSCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dsch_pkg.sv =====
package dsch_pkg;

  // Fixed geometry of the bins
  localparam int BIN_COUNT = 256;
  localparam int BIN_W     = 8;

  // Datapath widths
  localparam int VAL_W  = 20;  // signed Q8.12 channel value
  localparam int PEAK_W = 19;  // unsigned Q7.12 peak
  localparam int DIV_W  = 30;  // dividend / divisor of the bin divider
  localparam int LG_W   = 21;  // log2 result: 5 integer, 16 fraction bits
  localparam int CFG_W  = 13;

  localparam logic [PEAK_W-1:0] PEAK_ONE = 19'd4096;
  // log2(4096) in Q5.16
  localparam logic signed [LG_W:0] LG_BIAS = 22'sd786432;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_ACC   = 2'd2,
    CMD_READ  = 2'd3
  } dsch_cmd_e;

  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_SKIP_INTERVAL = 2'd1,
    CFG_HDR_ENABLE    = 2'd2
  } dsch_cfg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEN,
    ST_CH_GO,
    ST_LIN,
    ST_NUM_GO,
    ST_NUM,
    ST_LDIV_GO,
    ST_LDIV,
    ST_MEM_RD,
    ST_MEM_WR,
    ST_RD_OUT
  } dsch_state_e;

endpackage

// ===== rtl/core/dsch_if.sv =====
// Request channel: commands and pixels
interface dsch_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [19:0] channel_0;
  logic signed [19:0] channel_1;
  logic signed [19:0] channel_2;
  logic signed [19:0] channel_3;
  logic [1:0]        read_channel;
  logic [7:0]        read_bin;

  modport source (output valid, command, channel_0, channel_1, channel_2, channel_3,
                  read_channel, read_bin, input ready);
  modport sink (input valid, command, channel_0, channel_1, channel_2, channel_3,
                read_channel, read_bin, output ready);
endinterface

// Response channel: bin counts and peak
interface dsch_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] linear_count;
  logic [31:0] log_count;
  logic [18:0] peak_value;

  modport source (output valid, linear_count, log_count, peak_value, input ready);
  modport sink (input valid, linear_count, log_count, peak_value, output ready);
endinterface

// ===== rtl/core/dsch_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient clamped to 255.
module dsch_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dsch_pkg::DIV_W-1:0] num_i,
  input  logic [dsch_pkg::DIV_W-1:0] den_i,
  output logic                       done_o,
  output logic [7:0]                 quot_o
);

  logic [dsch_pkg::DIV_W-1:0] rem_q;
  logic [dsch_pkg::DIV_W-1:0] dsh_q;
  logic [8:0]                 quot_q;
  logic [3:0]                 cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic                       fit;

  assign fit = rem_q >= dsh_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd8;
      end else if (busy_q) begin
        if (cnt_q == 4'd0) busy_q <= 1'b0;
        else cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  // datapath: bit 8 of the quotient flags overflow past 255
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= den_i << 8;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fit) rem_q <= rem_q - dsh_q;
      quot_q <= {quot_q[7:0], fit};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q[8] ? 8'hFF : quot_q[7:0];

endmodule

// ===== rtl/core/dsch_log2.sv =====
// Fixed-point log2 in Q5.16: normalize one bit a cycle, then one
// squaring round per fraction bit.
module dsch_log2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dsch_pkg::DIV_W-1:0] n_i,
  output logic                       done_o,
  output logic [dsch_pkg::LG_W-1:0]  res_o
);

  logic [30:0] m_q;
  logic [4:0]  e_q;
  logic [15:0] frac_q;
  logic [3:0]  rnd_q;
  logic        busy_q;
  logic        norm_q;
  logic        done_q;
  logic [61:0] sq;
  logic [31:0] m2;

  // Q1.30 square, back to Q2.30
  assign sq = 62'(m_q) * 62'(m_q);
  assign m2 = sq[61:30];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      norm_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= busy_q && !norm_q && (rnd_q == 4'd15);
      if (start_i) begin
        busy_q <= 1'b1;
        norm_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (norm_q) begin
          if (m_q[30]) norm_q <= 1'b0;
        end else begin
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == 4'd15) busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q    <= {1'b0, n_i};
      e_q    <= 5'd30;
      frac_q <= '0;
    end else if (busy_q) begin
      if (norm_q) begin
        if (!m_q[30]) begin
          m_q <= m_q << 1;
          e_q <= e_q - 5'd1;
        end
      end else if (m2[31]) begin
        m_q    <= m2[31:1];
        frac_q <= {frac_q[14:0], 1'b1};
      end else begin
        m_q    <= m2[30:0];
        frac_q <= {frac_q[14:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = {e_q, frac_q};

endmodule

// ===== rtl/core/dsch_bin_mem.sv =====
// Bin counter memory: one write port, one registered read port.
module dsch_bin_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/dual_scale_channel_histogram.sv =====
// Linear and logarithmic per-channel histogram over Q8.12 pixels. Commands
// are handled one at a time. After reset and after every clear command the
// block sweeps all MAX_CHANNELS*256 entries of both bin memories to zero, one
// entry a cycle, with req_i.ready low. Scan and skipped accumulates finish as
// they are taken; a read is answered from ST_RD_OUT once the response register
// is free. A counted pixel first runs log2 of ten times the peak (normalize
// plus 16 squaring rounds), then per channel, for a positive value, a bin
// division, a second log2 and, for a positive log, a division, and then a
// read-modify-write of the two bin memories (ST_MEM_RD, ST_MEM_WR). The pace
// is set by the log2 unit and the divider, which all channels share.
module dual_scale_channel_histogram #(
  parameter int MAX_CHANNELS = 4,
  parameter int COUNT_BITS   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [dsch_pkg::CFG_W-1:0] cfg_wdata_i,
  dsch_req_if.sink                   req_i,
  dsch_rsp_if.source                 rsp_o
);

  localparam int Depth   = MAX_CHANNELS * dsch_pkg::BIN_COUNT;
  localparam int AddrW   = $clog2(Depth);
  localparam int MaxUsed = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;

  dsch_pkg::dsch_state_e state_q, state_d;

  logic [2:0]                  cc_q;
  logic [dsch_pkg::CFG_W-1:0]  si_q;
  logic                        hdr_q;
  logic [dsch_pkg::PEAK_W-1:0] peak_q;
  logic [dsch_pkg::CFG_W-1:0]  skip_q;
  logic [AddrW-1:0]            sweep_q;
  logic [1:0]                  ch_idx_q;
  logic signed [dsch_pkg::VAL_W-1:0] pix_q [4];
  logic [19:0]                 den_q;
  logic [19:0]                 num_q;
  logic                        num_pos_q;
  logic [7:0]                  lin_bin_q;
  logic [7:0]                  log_bin_q;
  logic                        rc_ok_q;
  logic                        out_valid_q;
  logic [31:0]                 lin_out_q;
  logic [31:0]                 log_out_q;
  logic [dsch_pkg::PEAK_W-1:0] peak_out_q;

  logic                        accept;
  logic                        acc_pass;
  logic                        rc_ok;
  logic                        out_free;
  logic [2:0]                  n_used;
  logic signed [dsch_pkg::VAL_W-1:0] ch_in [4];
  logic [dsch_pkg::PEAK_W-1:0] peak_scan;
  logic signed [dsch_pkg::VAL_W-1:0] v;
  logic                        v_pos;
  logic signed [dsch_pkg::LG_W:0] lg_rel;

  logic                        div_start, div_done;
  logic [dsch_pkg::DIV_W-1:0]  div_num, div_den;
  logic [7:0]                  div_quot;
  logic                        lg_start, lg_done;
  logic [dsch_pkg::DIV_W-1:0]  lg_n;
  logic [dsch_pkg::LG_W-1:0]   lg_res;

  logic                        mem_we, mem_re;
  logic [AddrW-1:0]            lin_waddr, log_waddr, lin_raddr, log_raddr;
  logic [AddrW-1:0]            lin_addr, log_addr, rd_addr;
  logic [COUNT_BITS-1:0]       lin_rdata, log_rdata, lin_wdata, log_wdata;
  logic [31:0]                 lin_sat, log_sat;

  // channels in use and request decode
  assign n_used   = (32'(cc_q) > MaxUsed) ? 3'(MaxUsed) : cc_q;
  assign accept   = req_i.valid && req_i.ready;
  assign acc_pass = accept && (req_i.command == dsch_pkg::CMD_ACC) && (skip_q <= 13'd1)
                    && (n_used != 3'd0);
  assign rc_ok    = 32'(req_i.read_channel) < MAX_CHANNELS;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign ch_in[0] = req_i.channel_0;
  assign ch_in[1] = req_i.channel_1;
  assign ch_in[2] = req_i.channel_2;
  assign ch_in[3] = req_i.channel_3;

  // running peak over the used channels of a scan
  always_comb begin
    peak_scan = peak_q;
    for (int c = 0; c < 4; c++) begin
      if (3'(c) < n_used && !ch_in[c][19] && ch_in[c][18:0] > peak_scan) begin
        peak_scan = ch_in[c][18:0];
      end
    end
  end

  // current channel value and log2 relative to 1.0
  assign v      = pix_q[ch_idx_q];
  assign v_pos  = !v[19] && (|v[18:0]);
  assign lg_rel = $signed({1'b0, lg_res}) - dsch_pkg::LG_BIAS;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsch_pkg::ST_CLEAR:   if (sweep_q == AddrW'(Depth - 1)) state_d = dsch_pkg::ST_IDLE;
      dsch_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.command)
            dsch_pkg::CMD_CLEAR: state_d = dsch_pkg::ST_CLEAR;
            dsch_pkg::CMD_READ:  state_d = dsch_pkg::ST_RD_OUT;
            dsch_pkg::CMD_ACC:   if (acc_pass) state_d = dsch_pkg::ST_DEN;
            default:             state_d = dsch_pkg::ST_IDLE;
          endcase
        end
      end
      dsch_pkg::ST_DEN:     if (lg_done) state_d = dsch_pkg::ST_CH_GO;
      dsch_pkg::ST_CH_GO:   state_d = v_pos ? dsch_pkg::ST_LIN : dsch_pkg::ST_MEM_RD;
      dsch_pkg::ST_LIN:     if (div_done) state_d = dsch_pkg::ST_NUM_GO;
      dsch_pkg::ST_NUM_GO:  state_d = dsch_pkg::ST_NUM;
      dsch_pkg::ST_NUM:     if (lg_done) state_d = dsch_pkg::ST_LDIV_GO;
      dsch_pkg::ST_LDIV_GO: state_d = num_pos_q ? dsch_pkg::ST_LDIV : dsch_pkg::ST_MEM_RD;
      dsch_pkg::ST_LDIV:    if (div_done) state_d = dsch_pkg::ST_MEM_RD;
      dsch_pkg::ST_MEM_RD:  state_d = dsch_pkg::ST_MEM_WR;
      dsch_pkg::ST_MEM_WR: begin
        state_d = (3'(ch_idx_q) + 3'd1 < n_used) ? dsch_pkg::ST_CH_GO : dsch_pkg::ST_IDLE;
      end
      dsch_pkg::ST_RD_OUT:  if (out_free) state_d = dsch_pkg::ST_IDLE;
      default:              state_d = dsch_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: unit launches and memory strobes
  always_comb begin
    req_i.ready = (state_q == dsch_pkg::ST_IDLE);
    lg_start    = (state_q == dsch_pkg::ST_IDLE && acc_pass) ||
                  (state_q == dsch_pkg::ST_NUM_GO);
    div_start   = (state_q == dsch_pkg::ST_CH_GO && v_pos) ||
                  (state_q == dsch_pkg::ST_LDIV_GO && num_pos_q);
    mem_we      = (state_q == dsch_pkg::ST_CLEAR) || (state_q == dsch_pkg::ST_MEM_WR);
    mem_re      = (state_q == dsch_pkg::ST_MEM_RD) ||
                  (accept && req_i.command == dsch_pkg::CMD_READ && rc_ok);
  end

  // unit operands
  assign lg_n = (state_q == dsch_pkg::ST_IDLE) ? 30'(peak_q) * 30'd10
                                                 : 30'(v[18:0]) * 30'd10;
  always_comb begin
    if (state_q == dsch_pkg::ST_CH_GO) begin
      div_num = 30'(v[18:0]) * 30'd510 + 30'(peak_q);
      div_den = 30'({peak_q, 1'b0});
    end else begin
      div_num = 30'(num_q) * 30'd510 + 30'(den_q);
      div_den = 30'({den_q, 1'b0});
    end
  end

  dsch_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  dsch_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .n_i     (lg_n),
    .done_o  (lg_done),
    .res_o   (lg_res)
  );

  // bin addressing
  assign lin_addr  = (AddrW'(ch_idx_q) << dsch_pkg::BIN_W) | AddrW'(lin_bin_q);
  assign log_addr  = (AddrW'(ch_idx_q) << dsch_pkg::BIN_W) | AddrW'(log_bin_q);
  assign rd_addr   = (AddrW'(req_i.read_channel) << dsch_pkg::BIN_W) | AddrW'(req_i.read_bin);
  assign lin_raddr = (state_q == dsch_pkg::ST_MEM_RD) ? lin_addr : rd_addr;
  assign log_raddr = (state_q == dsch_pkg::ST_MEM_RD) ? log_addr : rd_addr;
  assign lin_waddr = (state_q == dsch_pkg::ST_CLEAR) ? sweep_q : lin_addr;
  assign log_waddr = (state_q == dsch_pkg::ST_CLEAR) ? sweep_q : log_addr;

  // saturating increment, zero during the sweep
  always_comb begin
    if (state_q == dsch_pkg::ST_CLEAR) begin
      lin_wdata = '0;
      log_wdata = '0;
    end else begin
      lin_wdata = (&lin_rdata) ? lin_rdata : lin_rdata + COUNT_BITS'(1);
      log_wdata = (&log_rdata) ? log_rdata : log_rdata + COUNT_BITS'(1);
    end
  end

  dsch_bin_mem #(.DEPTH(Depth), .WIDTH(COUNT_BITS)) u_lin_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lin_waddr),
    .wdata_i (lin_wdata),
    .re_i    (mem_re),
    .raddr_i (lin_raddr),
    .rdata_o (lin_rdata)
  );

  dsch_bin_mem #(.DEPTH(Depth), .WIDTH(COUNT_BITS)) u_log_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (log_waddr),
    .wdata_i (log_wdata),
    .re_i    (mem_re),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  // counts fitted to the 32-bit response fields
  if (COUNT_BITS > 32) begin : g_sat
    assign lin_sat = (|lin_rdata[COUNT_BITS-1:32]) ? '1 : lin_rdata[31:0];
    assign log_sat = (|log_rdata[COUNT_BITS-1:32]) ? '1 : log_rdata[31:0];
  end else begin : g_ext
    assign lin_sat = 32'(lin_rdata);
    assign log_sat = 32'(log_rdata);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsch_pkg::ST_CLEAR;
      sweep_q     <= '0;
      cc_q        <= 3'd4;
      si_q        <= 13'd1;
      hdr_q       <= 1'b0;
      peak_q      <= dsch_pkg::PEAK_ONE;
      skip_q      <= 13'd1;
      ch_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dsch_pkg::CFG_CHANNEL_COUNT: cc_q  <= cfg_wdata_i[2:0];
          dsch_pkg::CFG_SKIP_INTERVAL: si_q  <= cfg_wdata_i;
          dsch_pkg::CFG_HDR_ENABLE:    hdr_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      // clear sweep
      if (state_q == dsch_pkg::ST_CLEAR) sweep_q <= sweep_q + AddrW'(1);
      else sweep_q <= '0;

      // command effects
      if (accept) begin
        case (req_i.command)
          dsch_pkg::CMD_CLEAR: begin
            peak_q <= dsch_pkg::PEAK_ONE;
            skip_q <= si_q;
          end
          dsch_pkg::CMD_SCAN: if (hdr_q) peak_q <= peak_scan;
          dsch_pkg::CMD_ACC: begin
            if (skip_q <= 13'd1) skip_q <= (si_q == '0) ? 13'd1 : si_q;
            else skip_q <= skip_q - 13'd1;
          end
          default: ;
        endcase
      end

      // channel walk of a counted pixel
      if (acc_pass) ch_idx_q <= '0;
      else if (state_q == dsch_pkg::ST_MEM_WR) ch_idx_q <= ch_idx_q + 2'd1;

      // response register
      if (state_q == dsch_pkg::ST_RD_OUT && out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_pass) begin
      for (int c = 0; c < 4; c++) pix_q[c] <= ch_in[c];
    end
    if (accept) rc_ok_q <= rc_ok;
    if (state_q == dsch_pkg::ST_DEN && lg_done) den_q <= lg_rel[19:0];
    if (state_q == dsch_pkg::ST_NUM && lg_done) begin
      num_q     <= lg_rel[19:0];
      num_pos_q <= !lg_rel[dsch_pkg::LG_W] && (|lg_rel);
    end
    if (state_q == dsch_pkg::ST_CH_GO && !v_pos) begin
      lin_bin_q <= '0;
      log_bin_q <= '0;
    end
    if (state_q == dsch_pkg::ST_LIN && div_done) lin_bin_q <= div_quot;
    if (state_q == dsch_pkg::ST_LDIV_GO && !num_pos_q) log_bin_q <= '0;
    if (state_q == dsch_pkg::ST_LDIV && div_done) log_bin_q <= div_quot;
    if (state_q == dsch_pkg::ST_RD_OUT && out_free) begin
      lin_out_q  <= rc_ok_q ? lin_sat : '0;
      log_out_q  <= rc_ok_q ? log_sat : '0;
      peak_out_q <= peak_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.linear_count = lin_out_q;
  assign rsp_o.log_count    = log_out_q;
  assign rsp_o.peak_value   = peak_out_q;

endmodule

// ===== rtl/core/dsch_checker.sv =====
`include "dual_scale_channel_histogram_macros.svh"

// Port-level checks of the histogram.
module dsch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_command_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_linear_i,
  input logic [31:0] rsp_log_i,
  input logic [18:0] rsp_peak_i
);

  logic req_take;
  logic busy_cmd;

  assign req_take = req_valid_i && req_ready_i;
  assign busy_cmd = req_take && (req_command_i == dsch_pkg::CMD_CLEAR ||
                                 req_command_i == dsch_pkg::CMD_READ);

  // a stalled response holds
  `DSCH_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_linear_i) && $stable(rsp_log_i) && $stable(rsp_peak_i), "response changed while stalled")

  // the peak never drops below 1.0
  `DSCH_ASSERT(a_peak_floor, clk_i, rst_ni, !rsp_valid_i || rsp_peak_i >= 19'd4096, "peak below one")

  // clear and read close the request side in the cycle after they are taken
  `DSCH_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, busy_cmd, !req_ready_i, "ready right after clear or read")

  // a new response only follows a read request
  `DSCH_ASSERT(a_rsp_source, clk_i, rst_ni, !$rose(rsp_valid_i) || $past(req_take && req_command_i == dsch_pkg::CMD_READ, 2), "response without read")

endmodule

bind dual_scale_channel_histogram dsch_checker u_dsch_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_command_i (req_i.command),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_linear_i  (rsp_o.linear_count),
  .rsp_log_i     (rsp_o.log_count),
  .rsp_peak_i    (rsp_o.peak_value)
);

// ===== tb/dsch_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces are provided by the RTL (dsch_req_if, dsch_rsp_if).
// This file holds the request and response records of the testbench.
package dsch_tb_pkg;
  import dsch_pkg::*;

  typedef struct packed {
    dsch_cmd_e          cmd;
    logic signed [19:0] ch0;
    logic signed [19:0] ch1;
    logic signed [19:0] ch2;
    logic signed [19:0] ch3;
    logic [1:0]         rd_ch;
    logic [7:0]         rd_bin;
  } pixel_req_t;

  typedef struct packed {
    logic [31:0] lin;
    logic [31:0] lg;
    logic [18:0] peak;
  } bin_rsp_t;
endpackage

// ===== tb/dual_scale_channel_histogram_tb.sv =====
`timescale 1ns / 1ps
module dual_scale_channel_histogram_tb;
  import dsch_pkg::*;
  import dsch_tb_pkg::*;

  localparam int NCH = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  dsch_req_if req_if ();
  dsch_rsp_if rsp_if ();

  dual_scale_channel_histogram u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state
  logic [31:0] lin_hist [NCH*256];
  logic [31:0] log_hist [NCH*256];
  logic [19:0] cur_peak;
  logic [12:0] skip_left;
  logic [2:0]  ch_count;
  logic [12:0] skip_every;
  logic        hdr_on;

  bin_rsp_t read_queue[$];
  int errors = 0;
  int reads_seen = 0;
  int pct_send_idle = 0;
  int pct_recv_idle = 0;

  function automatic longint fix_log2(longint n);
    int e;
    longint m, frac;
    e = 0;
    frac = 0;
    while (((n >> (e + 1)) != 0) && e < 62) e++;
    m = n << (30 - e);
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (longint'(1) << 31)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << (16 - i));
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic int lin_bin_of(longint v);
    longint q;
    if (v <= 0) return 0;
    q = (510 * v + cur_peak) / (2 * longint'(cur_peak));
    return q > 255 ? 255 : int'(q);
  endfunction

  function automatic int log_bin_of(longint v);
    longint num, den, q;
    if (v <= 0) return 0;
    num = fix_log2(10 * v) - (longint'(12) << 16);
    den = fix_log2(10 * longint'(cur_peak)) - (longint'(12) << 16);
    if (num <= 0 || den <= 0) return 0;
    q = (510 * num + den) / (2 * den);
    return q > 255 ? 255 : int'(q);
  endfunction

  function automatic void hist_clear();
    for (int i = 0; i < NCH*256; i++) begin
      lin_hist[i] = '0;
      log_hist[i] = '0;
    end
    cur_peak = 20'd4096;
    skip_left = skip_every;
  endfunction

  function automatic void apply_cfg(dsch_cfg_e idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_CHANNEL_COUNT: ch_count = val[2:0];
      CFG_SKIP_INTERVAL: skip_every = val[12:0];
      default: hdr_on = val[0];
    endcase
  endfunction

  // Model one accepted request; reads push an expected response
  function automatic void predict_hist(pixel_req_t r);
    longint v[4];
    int n, lb, gb;
    bin_rsp_t e;
    v[0] = r.ch0; v[1] = r.ch1; v[2] = r.ch2; v[3] = r.ch3;
    n = ch_count > NCH ? NCH : ch_count;
    case (r.cmd)
      CMD_CLEAR: hist_clear();
      CMD_SCAN: begin
        if (hdr_on)
          for (int c = 0; c < n; c++)
            if (v[c] > longint'(cur_peak)) cur_peak = v[c][19:0];
      end
      CMD_ACC: begin
        if (skip_left <= 1) begin
          for (int c = 0; c < n; c++) begin
            lb = lin_bin_of(v[c]);
            gb = log_bin_of(v[c]);
            if (lin_hist[c*256+lb] != 32'hFFFFFFFF) lin_hist[c*256+lb]++;
            if (log_hist[c*256+gb] != 32'hFFFFFFFF) log_hist[c*256+gb]++;
          end
          skip_left = skip_every == 0 ? 13'd1 : skip_every;
        end else begin
          skip_left--;
        end
      end
      default: begin
        e.lin = lin_hist[r.rd_ch*256 + r.rd_bin];
        e.lg = log_hist[r.rd_ch*256 + r.rd_bin];
        e.peak = cur_peak[18:0];
        read_queue.push_back(e);
      end
    endcase
  endfunction

  // Response checker and receiver stalls
  initial rsp_if.ready = 1'b0;
  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(99) >= pct_recv_idle);

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      reads_seen++;
      if (read_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected response lin=%0d log=%0d peak=%0d", $time,
                 rsp_if.linear_count, rsp_if.log_count, rsp_if.peak_value);
      end else begin
        bin_rsp_t e;
        e = read_queue.pop_front();
        if (e.lin !== rsp_if.linear_count) begin
          errors++;
          $display("%0t: linear_count expected %0d actual %0d", $time, e.lin,
                   rsp_if.linear_count);
        end
        if (e.lg !== rsp_if.log_count) begin
          errors++;
          $display("%0t: log_count expected %0d actual %0d", $time, e.lg,
                   rsp_if.log_count);
        end
        if (e.peak !== rsp_if.peak_value) begin
          errors++;
          $display("%0t: peak_value expected %0d actual %0d", $time, e.peak,
                   rsp_if.peak_value);
        end
      end
    end
  end

  // Send one request; predict on acceptance
  task automatic send_req(pixel_req_t r);
    while ($urandom_range(99) < pct_send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= r.cmd;
    req_if.channel_0 <= r.ch0;
    req_if.channel_1 <= r.ch1;
    req_if.channel_2 <= r.ch2;
    req_if.channel_3 <= r.ch3;
    req_if.read_channel <= r.rd_ch;
    req_if.read_bin <= r.rd_bin;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_hist(r);
    @(negedge clk_i);
  endtask

  // wait until every response is in and the block is idle again
  task automatic drain_rsp();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (read_queue.size() != 0 || !req_if.ready) @(negedge clk_i);
  endtask

  task automatic write_cfg(dsch_cfg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_cfg(idx, val);
    @(negedge clk_i);
  endtask

  function automatic logic [19:0] rand_val();
    case ($urandom_range(5))
      0: return 20'h80000 + $urandom_range(20'h7FFFF);
      1: return $urandom_range(20'h7FFFF);
      2: return $urandom_range(8192);
      3: return $urandom_range(40000);
      default: return $urandom_range(4096);
    endcase
  endfunction

  function automatic pixel_req_t rand_req(int acc_pct);
    pixel_req_t r;
    int k;
    k = $urandom_range(99);
    if (k < acc_pct) r.cmd = CMD_ACC;
    else if (k < acc_pct + 25) r.cmd = CMD_READ;
    else if (k < 98) r.cmd = CMD_SCAN;
    else r.cmd = CMD_CLEAR;
    r.ch0 = rand_val();
    r.ch1 = rand_val();
    r.ch2 = rand_val();
    r.ch3 = rand_val();
    r.rd_ch = $urandom_range(3);
    r.rd_bin = ($urandom_range(1) == 0) ? $urandom_range(255) : $urandom_range(255, 240);
    return r;
  endfunction

  // Directed rows: command, four channel values, read address, and for
  // plain cases a typed expected response (chk set)
  typedef struct {
    dsch_cmd_e cmd;
    int c0, c1, c2, c3, rch, rbin;
    bit chk;
    int elin, elog, epeak;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{CMD_READ, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 4096},
    '{CMD_READ, 0, 0, 0, 0, 3, 255, 1'b1, 0, 0, 4096},
    '{CMD_SCAN, 524287, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{CMD_READ, 0, 0, 0, 0, 1, 10, 1'b1, 0, 0, 4096},
    '{CMD_ACC, -524288, 0, 4096, 524287, 0, 0, 1'b0, 0, 0, 0},
    '{CMD_ACC, 1, 409, 410, 2048, 0, 0, 1'b0, 0, 0, 0},
    '{CMD_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{CMD_READ, 0, 0, 0, 0, 2, 255, 1'b0, 0, 0, 0},
    '{CMD_READ, 0, 0, 0, 0, 3, 255, 1'b1, 1, 1, 4096},
    '{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{CMD_READ, 0, 0, 0, 0, 3, 255, 1'b1, 0, 0, 4096}
  };

  pixel_req_t r;
  int sent;

  initial begin
    req_if.valid = 1'b0;
    req_if.command = CMD_CLEAR;
    req_if.channel_0 = '0;
    req_if.channel_1 = '0;
    req_if.channel_2 = '0;
    req_if.channel_3 = '0;
    req_if.read_channel = '0;
    req_if.read_bin = '0;
    ch_count = 3'd4;
    skip_every = 13'd1;
    hdr_on = 1'b0;
    hist_clear();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings
    foreach (dir_rows[i]) begin
      bin_rsp_t t;
      r.cmd = dir_rows[i].cmd;
      r.ch0 = dir_rows[i].c0;
      r.ch1 = dir_rows[i].c1;
      r.ch2 = dir_rows[i].c2;
      r.ch3 = dir_rows[i].c3;
      r.rd_ch = dir_rows[i].rch;
      r.rd_bin = dir_rows[i].rbin;
      send_req(r);
      if (dir_rows[i].chk) begin
        t.lin = 32'(dir_rows[i].elin);
        t.lg = 32'(dir_rows[i].elog);
        t.peak = 19'(dir_rows[i].epeak);
        void'(read_queue.pop_back());
        read_queue.push_back(t);
      end
    end
    drain_rsp();
    // HDR scan raises the peak, then reads show it
    write_cfg(CFG_HDR_ENABLE, 1);
    write_cfg(CFG_CHANNEL_COUNT, 7);
    write_cfg(CFG_SKIP_INTERVAL, 0);
    r = '{CMD_SCAN, 20'sd524287, 20'sd8192, -20'sd1, 20'sd0, 2'd0, 8'd0};
    send_req(r);
    r.cmd = CMD_ACC;
    send_req(r);
    r = '{CMD_READ, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 2'd0, 8'd255};
    send_req(r);
    drain_rsp();
    write_cfg(CFG_HDR_ENABLE, 0);
    write_cfg(CFG_CHANNEL_COUNT, 0);
    r.cmd = CMD_ACC;
    send_req(r);
    r.cmd = CMD_READ;
    send_req(r);
    drain_rsp();

    // Random phases over settings and idle mixes
    sent = 0;
    for (int ph = 0; ph < 9; ph++) begin
      pct_send_idle = ph < 3 ? 36 : (ph < 6 ? 69 : 0);
      pct_recv_idle = ph < 3 ? 69 : (ph < 6 ? 36 : 0);
      write_cfg(CFG_CHANNEL_COUNT, (ph % 3 == 0) ? 1 : $urandom_range(4));
      write_cfg(CFG_SKIP_INTERVAL, (ph == 4) ? 4096 : $urandom_range(3));
      write_cfg(CFG_HDR_ENABLE, ph % 2);
      for (int k = 0; k < 104; k++) begin
        r = rand_req(45);
        send_req(r);
        sent++;
        if (k == 50 && ph == 2) drain_rsp();
      end
      drain_rsp();
    end

    $display("Covered %0d random requests over 9 settings; %0d responses checked.",
             sent, reads_seen);
    if (errors == 0) begin
      $display("dual_scale_channel_histogram_tb passed");
    end else begin
      $display("dual_scale_channel_histogram_tb failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("dual_scale_channel_histogram_tb failed");
    $finish;
  end
endmodule
